### rtl/tda_pkg.sv
package tda_pkg;

	// default depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// register stages in the front pipeline
	localparam int FRONT_STAGES = 6;

	// reciprocal constants for the constant divisions
	// 86400 = 128 * 675, 3600 = 16 * 225, 60 = 4 * 15
	localparam logic [25:0] RECIP_675 = 26'd50903317;   // ceil(2^35 / 675)
	localparam logic [12:0] RECIP_225 = 13'd4661;       // ceil(2^20 / 225)
	localparam logic [10:0] RECIP_15  = 11'd1093;       // ceil(2^14 / 15)

	localparam logic [9:0]  DAY_DIV_128   = 10'd675;
	localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
	localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
	localparam logic [5:0]  MINS_PER_HOUR = 6'd60;
	localparam logic [4:0]  HOURS_PER_DAY = 5'd24;

	// operation codes, same encoding as the mode field
	typedef enum logic [1:0] {
		OP_SET  = 2'd0,
		OP_ADD  = 2'd1,
		OP_SUB  = 2'd2,
		OP_HOLD = 2'd3
	} op_t;

	// one queue entry: set values or the day-reduced delta in h/m/s
	typedef struct packed {
		op_t        op;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} entry_t;

	// handshake between two parts
	typedef struct packed {
		logic valid;
		logic ready;
	} hs_t;

endpackage

### rtl/tda_front.sv
module tda_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          mode,
	input  logic [31:0]         amount,
	input  logic [5:0]          set_hour,
	input  logic [5:0]          set_minute,
	input  logic [5:0]          set_second,
	input  logic                queue_full,
	output logic                push,
	output tda_pkg::entry_t     push_data
);

	logic adv;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	tda_pkg::entry_t info_s1, info_s2, info_s3, info_s4, info_s5, info_s6;

	logic [50:0] prod_s1;
	logic [24:0] a_s1;
	logic [6:0]  lo_s1;
	logic [16:0] delta_s2, delta_s3;
	logic [4:0]  hr_s3, hr_s4, hr_s5, hr_s6;
	logic [11:0] rem_s4, rem_s5;
	logic [5:0]  mn_s5, mn_s6;
	logic [5:0]  sc_s6;

	tda_pkg::entry_t info_in;
	logic [15:0] quot;
	logic [25:0] quot_x;
	logic [25:0] rem_day;
	logic [25:0] hr_prod;
	logic [16:0] hr_x;
	logic [16:0] rem_hr;
	logic [20:0] mn_prod;
	logic [11:0] mn_x;
	logic [11:0] rem_mn;

	// whole pipe holds while its last stage cannot enter the queue
	assign adv      = !(v_s6 && queue_full);
	assign in_ready = adv;
	assign push     = v_s6 && !queue_full;

	// classify and range-check the set fields
	always_comb begin
		info_in.op     = tda_pkg::op_t'(mode);
		info_in.hour   = (set_hour < 6'(tda_pkg::HOURS_PER_DAY)) ? set_hour[4:0] : '0;
		info_in.minute = (set_minute < tda_pkg::MINS_PER_HOUR) ? set_minute : '0;
		info_in.second = (set_second < tda_pkg::SECS_PER_MIN) ? set_second : '0;
	end

	// amount mod 86400: remainder of amount/128 by 675
	assign quot    = prod_s1[50:35];
	assign quot_x  = 26'(quot) * 26'(tda_pkg::DAY_DIV_128);
	assign rem_day = 26'(a_s1) - quot_x;

	// split the reduced delta into hours, minutes and seconds
	assign hr_prod = 26'(delta_s2[16:4]) * 26'(tda_pkg::RECIP_225);
	assign hr_x    = 17'(hr_s3) * 17'(tda_pkg::SECS_PER_HOUR);
	assign rem_hr  = delta_s3 - hr_x;
	assign mn_prod = 21'(rem_s4[11:2]) * 21'(tda_pkg::RECIP_15);
	assign mn_x    = 12'(mn_s5) * 12'(tda_pkg::SECS_PER_MIN);
	assign rem_mn  = rem_s5 - mn_x;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1  <= 51'(amount[31:7]) * 51'(tda_pkg::RECIP_675);
			a_s1     <= amount[31:7];
			lo_s1    <= amount[6:0];
			info_s1  <= info_in;

			delta_s2 <= {rem_day[9:0], lo_s1};
			info_s2  <= info_s1;

			delta_s3 <= delta_s2;
			hr_s3    <= hr_prod[24:20];
			info_s3  <= info_s2;

			hr_s4    <= hr_s3;
			rem_s4   <= rem_hr[11:0];
			info_s4  <= info_s3;

			hr_s5    <= hr_s4;
			rem_s5   <= rem_s4;
			mn_s5    <= mn_prod[19:14];
			info_s5  <= info_s4;

			hr_s6    <= hr_s5;
			mn_s6    <= mn_s5;
			sc_s6    <= rem_mn[5:0];
			info_s6  <= info_s5;
		end
	end

	// queue entry: set values or delta digits
	always_comb begin
		push_data.op = info_s6.op;
		if (info_s6.op == tda_pkg::OP_SET) begin
			push_data.hour   = info_s6.hour;
			push_data.minute = info_s6.minute;
			push_data.second = info_s6.second;
		end else begin
			push_data.hour   = hr_s6;
			push_data.minute = mn_s6;
			push_data.second = sc_s6;
		end
	end

endmodule

### rtl/tda_queue.sv
module tda_queue #(
	parameter int Depth = tda_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tda_pkg::entry_t push_data,
	output logic            full,
	output tda_pkg::hs_t    pop_hs,
	input  logic            pop_ready,
	output tda_pkg::entry_t pop_data
);

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	tda_pkg::entry_t mem_q [Depth];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic pop;

	assign full            = (count_q == CW'(Depth));
	assign pop_hs.valid    = (count_q != '0);
	assign pop_hs.ready    = pop_ready;
	assign pop             = pop_hs.valid && pop_hs.ready;
	assign pop_data        = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/tda_back.sv
module tda_back (
	input  logic            clk,
	input  logic            arst_n,
	input  tda_pkg::hs_t    entry_hs,
	output logic            entry_ready,
	input  tda_pkg::entry_t entry,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [4:0]      hour,
	output logic [5:0]      minute,
	output logic [5:0]      second
);

	logic [4:0] hour_q;
	logic [5:0] minute_q, second_q;
	logic       out_valid_q;
	logic [4:0] out_hour_q;
	logic [5:0] out_minute_q, out_second_q;

	logic take;
	logic [6:0] s_sum, m_sum, s_dif, m_dif;
	logic [5:0] h_sum, h_dif;
	logic       c0, c1, b0, b1;
	logic [5:0] s_add, m_add, s_sub, m_sub;
	logic [4:0] h_add, h_sub;
	logic [4:0] h_nxt;
	logic [5:0] m_nxt, s_nxt;

	// take an entry whenever the output slot is free or draining
	assign entry_ready = !out_valid_q || out_ready;
	assign take        = entry_hs.valid && entry_ready;

	// mixed-radix add with carries
	always_comb begin
		s_sum = 7'(second_q) + 7'(entry.second);
		c0    = (s_sum >= 7'(tda_pkg::SECS_PER_MIN));
		s_add = c0 ? 6'(s_sum - 7'(tda_pkg::SECS_PER_MIN)) : s_sum[5:0];
		m_sum = 7'(minute_q) + 7'(entry.minute) + 7'(c0);
		c1    = (m_sum >= 7'(tda_pkg::MINS_PER_HOUR));
		m_add = c1 ? 6'(m_sum - 7'(tda_pkg::MINS_PER_HOUR)) : m_sum[5:0];
		h_sum = 6'(hour_q) + 6'(entry.hour) + 6'(c1);
		h_add = (h_sum >= 6'(tda_pkg::HOURS_PER_DAY)) ?
			5'(h_sum - 6'(tda_pkg::HOURS_PER_DAY)) : h_sum[4:0];
	end

	// mixed-radix subtract with borrows, wrapping the day
	always_comb begin
		s_dif = 7'(second_q) - 7'(entry.second);
		b0    = s_dif[6];
		s_sub = b0 ? 6'(s_dif + 7'(tda_pkg::SECS_PER_MIN)) : s_dif[5:0];
		m_dif = 7'(minute_q) - 7'(entry.minute) - 7'(b0);
		b1    = m_dif[6];
		m_sub = b1 ? 6'(m_dif + 7'(tda_pkg::MINS_PER_HOUR)) : m_dif[5:0];
		h_dif = 6'(hour_q) - 6'(entry.hour) - 6'(b1);
		h_sub = h_dif[5] ? 5'(h_dif + 6'(tda_pkg::HOURS_PER_DAY)) : h_dif[4:0];
	end

	// next time by operation
	always_comb begin
		case (entry.op)
			tda_pkg::OP_SET: begin
				h_nxt = entry.hour;
				m_nxt = entry.minute;
				s_nxt = entry.second;
			end
			tda_pkg::OP_ADD: begin
				h_nxt = h_add;
				m_nxt = m_add;
				s_nxt = s_add;
			end
			tda_pkg::OP_SUB: begin
				h_nxt = h_sub;
				m_nxt = m_sub;
				s_nxt = s_sub;
			end
			default: begin
				h_nxt = hour_q;
				m_nxt = minute_q;
				s_nxt = second_q;
			end
		endcase
	end

	// time of day and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hour_q      <= '0;
			minute_q    <= '0;
			second_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				hour_q      <= h_nxt;
				minute_q    <= m_nxt;
				second_q    <= s_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (take) begin
			out_hour_q   <= h_nxt;
			out_minute_q <= m_nxt;
			out_second_q <= s_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign hour      = out_hour_q;
	assign minute    = out_minute_q;
	assign second    = out_second_q;

endmodule

### rtl/time_of_day_adjust.sv
// channel  | signals                       | contents
// ---------+-------------------------------+------------------------------------------
// s_       | s_tvalid s_tready s_tdata     | command: amount, set_hour/minute/second
//          | s_tuser                       | mode (set, add, subtract, hold)
// m_       | m_tvalid m_tready m_tdata     | time after the command: hour, minute, second
//
// one transaction per cycle sustained while m_tready stays high; a result passes
// through the 6 front stages, the queue and the output register.
// the front pipeline holds as a whole only while its last stage meets a full queue.
// the back updates the time and loads the output register in the same cycle.
// arst_n clears the time to 00:00:00 and empties all stages and the queue.
module time_of_day_adjust #(
	parameter int QueueDepth = tda_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // amount[31:0], set_hour[37:32], set_minute[43:38],
	                               // set_second[49:44], zero fill
	input  logic [1:0]  s_tuser,   // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // hour[4:0], minute[10:5], second[16:11], zero fill
);

	logic            push;
	logic            queue_full;
	tda_pkg::entry_t push_data;
	tda_pkg::entry_t pop_data;
	tda_pkg::hs_t    pop_hs;
	logic            pop_ready;
	logic [4:0]      hour;
	logic [5:0]      minute, second;

	// classify and reduce commands
	tda_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.mode       (s_tuser),
		.amount     (s_tdata[31:0]),
		.set_hour   (s_tdata[37:32]),
		.set_minute (s_tdata[43:38]),
		.set_second (s_tdata[49:44]),
		.queue_full (queue_full),
		.push       (push),
		.push_data  (push_data)
	);

	// decoupling queue
	tda_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (queue_full),
		.pop_hs    (pop_hs),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	// apply to the time of day
	tda_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry_hs    (pop_hs),
		.entry_ready (pop_ready),
		.entry       (pop_data),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.hour        (hour),
		.minute      (minute),
		.second      (second)
	);

	assign m_tdata = {7'b0, second, minute, hour};

endmodule

### rtl/tda_checker.sv
module tda_checker #(
	parameter int QueueDepth = tda_pkg::QUEUE_DEPTH
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	localparam int Capacity = tda_pkg::FRONT_STAGES + QueueDepth + 1;
	localparam int CW       = $clog2(Capacity + 2);

	logic          in_acc, out_acc;
	logic [CW-1:0] inflight_q;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_acc && !out_acc) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// the reported time is a valid time of day
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[4:0] < 5'd24) && (m_tdata[10:5] < 6'd60)
			&& (m_tdata[16:11] < 6'd60) && (m_tdata[23:17] == '0))
		else $error("time of day out of range");

	// no result without a command behind it
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> inflight_q != '0)
		else $error("result shown with no command outstanding");

	// never more in flight than the stages can hold
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CW'(Capacity))
		else $error("more commands in flight than storage");

endmodule

bind time_of_day_adjust tda_checker #(
	.QueueDepth (QueueDepth)
) u_tda_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
